// ----- design/sobel_edge_magnitude_rgb_macros.svh -----
// assertion macros for the sobel edge magnitude block
`ifndef SOBEL_EDGE_MAGNITUDE_RGB_MACROS_SVH
`define SOBEL_EDGE_MAGNITUDE_RGB_MACROS_SVH
`ifndef SYNTHESIS
`define SEMR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SEMR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SEMR_ASSERT_NOW(label, ante, cons)
`define SEMR_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- design/semr_pkg.sv -----
// shared types and constants of the sobel edge magnitude block
`timescale 1ns / 1ps
package semr_pkg;
  localparam int unsigned MaxWidthDef   = 1024;
  localparam int unsigned MaxHeightDef  = 4096;
  localparam int unsigned FrameWidthW   = 11;
  localparam int unsigned FrameHeightW  = 13;
  localparam int unsigned CfgDataW      = 13;
  localparam int unsigned PixW          = 8;
  localparam int unsigned NumCh         = 3;
  localparam int unsigned GradW         = 12;
  localparam int unsigned SumW          = 21;
  localparam logic [FrameWidthW-1:0]  FrameWidthRst  = 11'd640;
  localparam logic [FrameHeightW-1:0] FrameHeightRst = 13'd480;
  localparam logic [SumW-1:0]         ClampLimit     = 21'd65280;

  localparam logic CfgIdxWidth  = 1'b0;
  localparam logic CfgIdxHeight = 1'b1;

  typedef logic [NumCh-1:0][PixW-1:0] rgb_t;

  typedef struct packed {
    rgb_t top;
    rgb_t mid;
    rgb_t bot;
  } column_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SQUARE,
    ST_ROOT,
    ST_ROUND
  } state_e;
endpackage

// ----- design/semr_ram.sv -----
// generic single-port ram with registered read
`timescale 1ns / 1ps
module semr_ram #(
  parameter int unsigned Width = 48,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     re_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ----- design/sobel_edge_magnitude_rgb.sv -----
// streaming 3x3 sobel gradient magnitude over rgb pixels
// Input items come in on s_axis in raster order; tuser set marks a drain item, which
// counts as a zero pixel. After the last pixel of a frame the host sends width+1
// drain items. Results leave on m_axis one row and one column behind the input,
// each a clamped round(sqrt(gx^2+gy^2)) for red, green and blue; tlast marks the
// final result of the frame, after which all position counters return to zero.
// Frame width and height are written over the cfg channel (index 0 width, 1 height)
// while the block is idle, a rule for the user that the block does not enforce.
// Zero counts as 1, large values saturate (width data is cut to 11 bits first).
// An item without a result passes ram read, then write back and window shift; one
// with a result passes ram read, gradients, squares, the bit-serial square root and
// the rounding step that loads the output register; the root loop sets throughput.
// The line stores live in one ram of MAX_WIDTH entries, both rows side by side.
// Reset clears counters, window and the output valid flag; ram contents are not
// cleared, since unwritten entries are only read at the top border where masked.
// When the receiver stalls, the result waits in the output register; the block
// takes the next item meanwhile and stalls only when it must load a new result.
`timescale 1ns / 1ps
`include "sobel_edge_magnitude_rgb_macros.svh"
module sobel_edge_magnitude_rgb #(
  parameter int unsigned MAX_WIDTH  = semr_pkg::MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = semr_pkg::MaxHeightDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [23:0]                   s_axis_tdata,  // red_in, green_in, blue_in
  input  logic                          s_axis_tuser,  // cmd
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [23:0]                   m_axis_tdata,  // red_edge, green_edge, blue_edge
  output logic                          m_axis_tlast,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_index_i,
  input  logic [semr_pkg::CfgDataW-1:0] cfg_data_i
);
  import semr_pkg::*;

  localparam int unsigned ColW = $clog2(MAX_WIDTH);
  localparam int unsigned WdW  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HtW  = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned RowW = $clog2(MAX_HEIGHT) + 2;
  localparam int unsigned RamW = 2 * $bits(rgb_t);

  state_e state_q, state_d;

  logic [FrameWidthW-1:0]  fw_q;
  logic [FrameHeightW-1:0] fh_q;
  logic [WdW-1:0]          w_act;
  logic [HtW-1:0]          h_act;

  logic [ColW-1:0] in_col_q, out_col_q, in_col_pre, out_col_pre;
  logic [RowW-1:0] in_row_q, out_row_q, in_row_pre, out_row_pre;
  rgb_t            pix_q;
  column_t         win1_q, win2_q, new_col;

  logic            ram_re, ram_we;
  logic [ColW-1:0] ram_addr;
  logic [RamW-1:0] ram_wdata, ram_rdata;

  logic emit, wrap, top_ok, bot_ok, left_ok, right_ok, last;
  logic [2:0] row_ok, col_ok;
  logic [ColW-1:0] in_col_inc, out_col_inc;
  logic            in_col_wrap, out_col_wrap;

  logic signed [GradW-1:0] gx_d [NumCh];
  logic signed [GradW-1:0] gy_d [NumCh];
  logic signed [GradW-1:0] gx_q [NumCh];
  logic signed [GradW-1:0] gy_q [NumCh];
  logic [SumW-1:0]         s_q  [NumCh];
  logic [PixW-1:0]         root_q [NumCh];
  logic [2:0]              bit_q;
  logic                    last_q;

  logic        m_valid_q, m_last_q;
  rgb_t        m_data_q;
  logic        out_free;

  // configuration
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= FrameWidthRst;
      fh_q <= FrameHeightRst;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CfgIdxWidth) begin
        fw_q <= cfg_data_i[FrameWidthW-1:0];
      end else begin
        fh_q <= cfg_data_i;
      end
    end
  end

  always_comb begin
    if (fw_q == '0) begin
      w_act = WdW'(1);
    end else if (32'(fw_q) > MAX_WIDTH) begin
      w_act = WdW'(MAX_WIDTH);
    end else begin
      w_act = WdW'(fw_q);
    end
    if (fh_q == '0) begin
      h_act = HtW'(1);
    end else if (32'(fh_q) > MAX_HEIGHT) begin
      h_act = HtW'(MAX_HEIGHT);
    end else begin
      h_act = HtW'(fh_q);
    end
  end

  // counters may sit past a width that was just lowered
  always_comb begin
    in_col_pre  = in_col_q;
    in_row_pre  = in_row_q;
    out_col_pre = out_col_q;
    out_row_pre = out_row_q;
    if (32'(in_col_q) >= 32'(w_act)) begin
      in_col_pre = '0;
      in_row_pre = in_row_q + RowW'(1);
    end
    if (32'(out_col_q) >= 32'(w_act)) begin
      out_col_pre = '0;
      out_row_pre = out_row_q + RowW'(1);
    end
  end

  // line ram: upper row in the high half, middle row in the low half
  semr_ram #(
    .Width (RamW),
    .Depth (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .re_i    (ram_re),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign new_col.top = ram_rdata[RamW-1 -: $bits(rgb_t)];
  assign new_col.mid = ram_rdata[$bits(rgb_t)-1:0];
  assign new_col.bot = pix_q;

  assign out_free = !m_valid_q || m_axis_tready;

  // window position and border masks
  always_comb begin
    emit     = (in_row_q >= RowW'(2)) || ((in_row_q == RowW'(1)) && (in_col_q != '0));
    wrap     = (in_col_q == '0);
    top_ok   = (out_row_q != '0);
    bot_ok   = (32'(out_row_q) + 32'd1) < 32'(h_act);
    left_ok  = (out_col_q != '0);
    right_ok = !wrap && ((32'(out_col_q) + 32'd1) < 32'(w_act));
    last     = !bot_ok && !((32'(out_col_q) + 32'd1) < 32'(w_act));
    row_ok   = {bot_ok, 1'b1, top_ok};
    col_ok   = {right_ok, 1'b1, left_ok};
    in_col_wrap  = (32'(in_col_q) + 32'd1) >= 32'(w_act);
    out_col_wrap = (32'(out_col_q) + 32'd1) >= 32'(w_act);
    in_col_inc   = in_col_q + ColW'(1);
    out_col_inc  = out_col_q + ColW'(1);
  end

  // gradients: left column win1, center win2, right the column just read
  always_comb begin
    logic [PixW-1:0] p [3][3];
    logic [9:0] sl, sr, st, sb;
    for (int c = 0; c < NumCh; c++) begin
      p[0][0] = win1_q.top[c];
      p[1][0] = win1_q.mid[c];
      p[2][0] = win1_q.bot[c];
      p[0][1] = win2_q.top[c];
      p[1][1] = win2_q.mid[c];
      p[2][1] = win2_q.bot[c];
      p[0][2] = new_col.top[c];
      p[1][2] = new_col.mid[c];
      p[2][2] = new_col.bot[c];
      for (int r = 0; r < 3; r++) begin
        for (int j = 0; j < 3; j++) begin
          if (!(row_ok[r] && col_ok[j])) begin
            p[r][j] = '0;
          end
        end
      end
      sl = {2'b0, p[0][0]} + {1'b0, p[1][0], 1'b0} + {2'b0, p[2][0]};
      sr = {2'b0, p[0][2]} + {1'b0, p[1][2], 1'b0} + {2'b0, p[2][2]};
      st = {2'b0, p[0][0]} + {1'b0, p[0][1], 1'b0} + {2'b0, p[0][2]};
      sb = {2'b0, p[2][0]} + {1'b0, p[2][1], 1'b0} + {2'b0, p[2][2]};
      gx_d[c] = $signed({2'b0, sr}) - $signed({2'b0, sl});
      gy_d[c] = $signed({2'b0, sb}) - $signed({2'b0, st});
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (s_axis_tvalid) state_d = ST_READ;
      ST_READ:   state_d = emit ? ST_SQUARE : ST_IDLE;
      ST_SQUARE: state_d = ST_ROOT;
      ST_ROOT:   if (bit_q == '0) state_d = ST_ROUND;
      ST_ROUND:  if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // handshake and ram control
  always_comb begin
    s_axis_tready = 1'b0;
    ram_re        = 1'b0;
    ram_we        = 1'b0;
    ram_addr      = in_col_pre;
    ram_wdata     = {new_col.mid, pix_q};
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        ram_re        = s_axis_tvalid;
      end
      ST_READ: begin
        ram_we   = 1'b1;
        ram_addr = in_col_q;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      win1_q    <= '0;
      win2_q    <= '0;
      bit_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_ROUND && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            in_col_q  <= in_col_pre;
            in_row_q  <= in_row_pre;
            out_col_q <= out_col_pre;
            out_row_q <= out_row_pre;
          end
        end
        ST_READ: begin
          win1_q <= win2_q;
          win2_q <= new_col;
          if (emit && last) begin
            in_col_q  <= '0;
            in_row_q  <= '0;
            out_col_q <= '0;
            out_row_q <= '0;
          end else begin
            if (in_col_wrap) begin
              in_col_q <= '0;
              in_row_q <= in_row_q + RowW'(1);
            end else begin
              in_col_q <= in_col_inc;
            end
            if (emit) begin
              if (out_col_wrap) begin
                out_col_q <= '0;
                out_row_q <= out_row_q + RowW'(1);
              end else begin
                out_col_q <= out_col_inc;
              end
            end
          end
        end
        ST_SQUARE: bit_q <= 3'd7;
        ST_ROOT:   bit_q <= bit_q - 3'd1;
        ST_ROUND:  bit_q <= '0;
        default:   bit_q <= '0;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    logic [PixW-1:0]   trial;
    logic [2*PixW-1:0] sq;
    logic [2*PixW-1:0] rem;
    logic signed [2*GradW-1:0] px2, py2;
    if (state_q == ST_IDLE && s_axis_tvalid) begin
      pix_q <= s_axis_tuser ? '0 : s_axis_tdata;
    end
    for (int c = 0; c < NumCh; c++) begin
      trial = root_q[c] | (PixW'(1) << bit_q);
      sq    = {{PixW{1'b0}}, trial} * {{PixW{1'b0}}, trial};
      rem   = s_q[c][2*PixW-1:0] - ({{PixW{1'b0}}, root_q[c]} * {{PixW{1'b0}}, root_q[c]});
      px2   = gx_q[c] * gx_q[c];
      py2   = gy_q[c] * gy_q[c];
      unique case (state_q)
        ST_READ: begin
          gx_q[c] <= gx_d[c];
          gy_q[c] <= gy_d[c];
        end
        ST_SQUARE: begin
          s_q[c]    <= SumW'($unsigned(px2)) + SumW'($unsigned(py2));
          root_q[c] <= '0;
        end
        ST_ROOT: begin
          if (sq <= s_q[c][2*PixW-1:0]) begin
            root_q[c] <= trial;
          end
        end
        ST_ROUND: begin
          if (out_free) begin
            if (s_q[c] > ClampLimit) begin
              m_data_q[c] <= '1;
            end else if (rem > {{PixW{1'b0}}, root_q[c]}) begin
              m_data_q[c] <= root_q[c] + PixW'(1);
            end else begin
              m_data_q[c] <= root_q[c];
            end
          end
        end
        default: begin
          root_q[c] <= root_q[c];
        end
      endcase
    end
    if (state_q == ST_READ) begin
      last_q <= last;
    end
    if (state_q == ST_ROUND && out_free) begin
      m_last_q <= last_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

  `SEMR_ASSERT_NEXT(a_accept_reads, s_axis_tvalid && s_axis_tready, state_q == ST_READ)
  `SEMR_ASSERT_NOW(a_out_from_round, $rose(m_valid_q), $past(state_q == ST_ROUND))
  `SEMR_ASSERT_NOW(a_root_bound, state_q == ST_ROUND,
                   ({{PixW{1'b0}}, root_q[0]} * {{PixW{1'b0}}, root_q[0]}) <= s_q[0][15:0])
endmodule
